// ===== hw/rtl/nvp_pkg.sv =====
package nvp_pkg;

  // widths fixed by the result fields
  localparam int NVP_STORE_BYTES = 14;
  localparam int NVP_LEN_W       = 4;
  localparam int NVP_CNT_W       = 6;

  // parameter defaults
  localparam int NVP_NAME_CHARS  = 14;
  localparam int NVP_MAX_PAIRS   = 32;
  localparam logic [NVP_CNT_W-1:0] NVP_LIMIT_RESET = 6'd32;

  // characters
  localparam logic [7:0] NVP_CH_NUL   = 8'h00;
  localparam logic [7:0] NVP_CH_EQ    = 8'h3D;
  localparam logic [7:0] NVP_CH_COMMA = 8'h2C;
  localparam logic [7:0] NVP_CH_PLUS  = 8'h2B;
  localparam logic [7:0] NVP_CH_MINUS = 8'h2D;
  localparam logic [7:0] NVP_CH_SPACE = 8'h20;
  localparam logic [7:0] NVP_CH_TAB   = 8'h09;
  localparam logic [7:0] NVP_CH_CR    = 8'h0D;
  localparam logic [7:0] NVP_CH_ZERO  = 8'h30;
  localparam logic [7:0] NVP_CH_NINE  = 8'h39;

  localparam logic [31:0] NVP_MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] NVP_POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CV_LEAD   = 2'd0,
    CV_DIGITS = 2'd1,
    CV_STOP   = 2'd2
  } conv_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [63:0]          name_low;
    logic [47:0]          name_high;
    logic [NVP_LEN_W-1:0] name_length;
    logic                 name_cut;
    logic signed [31:0]   pair_value;
    logic                 pair_present;
    logic                 text_end;
    logic [NVP_CNT_W-1:0] pairs_found;
  } out_t;

endpackage

// ===== hw/rtl/nvp_parser.sv =====
module nvp_parser #(
  parameter int NAME_CHARS = nvp_pkg::NVP_NAME_CHARS,
  parameter int MAX_PAIRS  = nvp_pkg::NVP_MAX_PAIRS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  nvp_pkg::in_t                      in_data,
  input  logic                              cfg_we,
  input  logic [nvp_pkg::NVP_CNT_W-1:0]     cfg_limit,
  output logic                              res_valid,
  output nvp_pkg::out_t                     res_data
);

  localparam int LW = nvp_pkg::NVP_LEN_W;
  localparam int CW = nvp_pkg::NVP_CNT_W;

  nvp_pkg::phase_t phase_r, phase_nxt;
  nvp_pkg::conv_t  cv_r, cv_nxt;
  logic [7:0]      store_r   [NAME_CHARS];
  logic [7:0]      store_nxt [NAME_CHARS];
  logic [LW-1:0]   count_r, count_nxt;
  logic            cut_r, cut_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic            neg_r, neg_nxt;
  logic [CW-1:0]   pairs_r, pairs_nxt;
  logic [CW-1:0]   limit_r;

  logic [7:0]      b;
  logic            is_end;
  logic            digit;
  logic            space;
  logic [CW-1:0]   limit;
  nvp_pkg::phase_t ph;
  logic            present;
  logic            wr_store;
  logic [31:0]     conv_acc;
  logic            conv_neg;
  nvp_pkg::conv_t  conv_cv;
  logic [34:0]     mac;
  logic [CW-1:0]   pairs_inc;
  logic [CW-1:0]   pairs_out;
  logic [31:0]     value;
  logic [nvp_pkg::NVP_STORE_BYTES*8-1:0] name_flat;

  assign b      = in_data.text_byte;
  assign is_end = (b == nvp_pkg::NVP_CH_NUL) || in_data.final_byte;
  assign digit  = (b >= nvp_pkg::NVP_CH_ZERO) && (b <= nvp_pkg::NVP_CH_NINE);
  assign space  = (b == nvp_pkg::NVP_CH_SPACE) ||
                  ((b >= nvp_pkg::NVP_CH_TAB) && (b <= nvp_pkg::NVP_CH_CR));
  assign limit  = (limit_r > CW'(MAX_PAIRS)) ? CW'(MAX_PAIRS) : limit_r;
  assign pairs_inc = pairs_r + CW'(1);

  // x*10 + digit, saturated to 2^31
  assign mac = ({3'b000, acc_r} << 3) + ({3'b000, acc_r} << 1) + 35'(b - nvp_pkg::NVP_CH_ZERO);

  // atoi step on one value byte
  always_comb begin
    conv_acc = acc_r;
    conv_neg = neg_r;
    conv_cv  = cv_r;
    case (cv_r)
      nvp_pkg::CV_LEAD: begin
        if (space) begin
          conv_cv = nvp_pkg::CV_LEAD;
        end else if (b == nvp_pkg::NVP_CH_PLUS || b == nvp_pkg::NVP_CH_MINUS) begin
          conv_neg = (b == nvp_pkg::NVP_CH_MINUS);
          conv_cv  = nvp_pkg::CV_DIGITS;
        end else if (digit) begin
          conv_cv  = nvp_pkg::CV_DIGITS;
          conv_acc = (mac > {3'b000, nvp_pkg::NVP_MAG_CAP}) ? nvp_pkg::NVP_MAG_CAP
                                                            : mac[31:0];
        end else begin
          conv_cv = nvp_pkg::CV_STOP;
        end
      end
      nvp_pkg::CV_DIGITS: begin
        if (digit) begin
          conv_acc = (mac > {3'b000, nvp_pkg::NVP_MAG_CAP}) ? nvp_pkg::NVP_MAG_CAP
                                                            : mac[31:0];
        end else begin
          conv_cv = nvp_pkg::CV_STOP;
        end
      end
      default: begin
        conv_cv = nvp_pkg::CV_STOP;
      end
    endcase
  end

  // name bytes padded with zeros out to the full field width
  genvar gi;
  generate
    for (gi = 0; gi < nvp_pkg::NVP_STORE_BYTES; gi++) begin : g_flat
      if (gi < NAME_CHARS) begin : g_used
        assign name_flat[8*gi +: 8] = store_r[gi];
      end else begin : g_pad
        assign name_flat[8*gi +: 8] = 8'h00;
      end
    end
  endgenerate

  always_comb begin
    phase_nxt = phase_r;
    cv_nxt    = cv_r;
    count_nxt = count_r;
    cut_nxt   = cut_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    pairs_nxt = pairs_r;
    for (int i = 0; i < NAME_CHARS; i++) begin
      store_nxt[i] = store_r[i];
    end
    present  = 1'b0;
    wr_store = 1'b0;

    ph = phase_r;
    if (phase_r == nvp_pkg::PH_NAME && pairs_r >= limit) begin
      ph = nvp_pkg::PH_DONE;
    end
    phase_nxt = ph;

    if (b != nvp_pkg::NVP_CH_NUL) begin
      case (ph)
        nvp_pkg::PH_NAME: begin
          if (b == nvp_pkg::NVP_CH_EQ) begin
            phase_nxt = nvp_pkg::PH_VALUE;
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            cv_nxt    = nvp_pkg::CV_LEAD;
          end else if (count_r < LW'(NAME_CHARS)) begin
            wr_store  = 1'b1;
            count_nxt = count_r + LW'(1);
          end else begin
            cut_nxt = 1'b1;
          end
        end
        nvp_pkg::PH_VALUE: begin
          if (b == nvp_pkg::NVP_CH_COMMA) begin
            present = 1'b1;
          end else begin
            acc_nxt = conv_acc;
            neg_nxt = conv_neg;
            cv_nxt  = conv_cv;
          end
        end
        default: begin
          phase_nxt = ph;
        end
      endcase
    end

    if (is_end && !present && phase_nxt == nvp_pkg::PH_VALUE) begin
      present = 1'b1;
    end

    for (int i = 0; i < NAME_CHARS; i++) begin
      if (wr_store && count_r == LW'(i)) begin
        store_nxt[i] = b;
      end
    end

    pairs_out = present ? pairs_inc : pairs_r;

    if (present) begin
      pairs_nxt = pairs_inc;
      // pair done: clear name and value
      for (int i = 0; i < NAME_CHARS; i++) begin
        store_nxt[i] = 8'h00;
      end
      count_nxt = '0;
      cut_nxt   = 1'b0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      cv_nxt    = nvp_pkg::CV_LEAD;
      phase_nxt = (pairs_inc >= limit) ? nvp_pkg::PH_DONE : nvp_pkg::PH_NAME;
    end

    if (is_end) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        store_nxt[i] = 8'h00;
      end
      count_nxt = '0;
      cut_nxt   = 1'b0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      cv_nxt    = nvp_pkg::CV_LEAD;
      phase_nxt = nvp_pkg::PH_NAME;
      pairs_nxt = '0;
    end
  end

  function automatic logic neg_nxt_src();
    return (ph == nvp_pkg::PH_VALUE && b != nvp_pkg::NVP_CH_COMMA) ? conv_neg : neg_r;
  endfunction

  function automatic logic [31:0] acc_src();
    return (ph == nvp_pkg::PH_VALUE && b != nvp_pkg::NVP_CH_COMMA) ? conv_acc : acc_r;
  endfunction

  // pair values come from the state after this byte's conversion step
  always_comb begin
    if (neg_nxt_src()) begin
      value = 32'(32'd0 - acc_src());
    end else begin
      value = (acc_src() > nvp_pkg::NVP_POS_MAX) ? nvp_pkg::NVP_POS_MAX : acc_src();
    end
  end

  always_comb begin
    res_valid             = present || is_end;
    res_data              = '0;
    res_data.text_end     = is_end;
    res_data.pairs_found  = pairs_out;
    res_data.pair_present = present;
    if (present) begin
      res_data.name_low    = name_flat[63:0];
      res_data.name_high   = name_flat[111:64];
      res_data.name_length = count_r;
      res_data.name_cut    = cut_r;
      res_data.pair_value  = value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nvp_pkg::PH_NAME;
      cv_r    <= nvp_pkg::CV_LEAD;
      count_r <= '0;
      cut_r   <= 1'b0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      pairs_r <= '0;
      limit_r <= nvp_pkg::NVP_LIMIT_RESET;
      for (int i = 0; i < NAME_CHARS; i++) begin
        store_r[i] <= 8'h00;
      end
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        cv_r    <= cv_nxt;
        count_r <= count_nxt;
        cut_r   <= cut_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        pairs_r <= pairs_nxt;
        for (int i = 0; i < NAME_CHARS; i++) begin
          store_r[i] <= store_nxt[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/nvp_out_queue.sv =====
module nvp_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nvp_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output nvp_pkg::out_t out_data
);

  logic          ov_r, ov_nxt;
  logic          sv_r, sv_nxt;
  nvp_pkg::out_t od_r, od_nxt;
  nvp_pkg::out_t sd_r, sd_nxt;
  logic          pop;

  assign pop = ov_r && !out_stall;

  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    od_nxt = od_r;
    sd_nxt = sd_r;
    if (pop) begin
      if (sv_r) begin
        // skid moves up, no push can arrive while skid is full
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = push;
        od_nxt = push_data;
      end
    end else if (!ov_r) begin
      ov_nxt = push;
      od_nxt = push_data;
    end else if (push) begin
      sv_nxt = 1'b1;
      sd_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

  assign full      = sv_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== hw/rtl/name_value_pair_parser.sv =====
// channel  direction  payload          handshake
// in_      input      nvp_pkg::in_t    in_valid / in_stall
// out_     output     nvp_pkg::out_t   out_valid / out_stall
// cfg_     input      pair_limit       cfg_valid / cfg_ready
//
// one byte a cycle unless stalled; each accepted beat is parsed in the cycle
// it is taken and its result, if any, enters the result queue on the next edge
// a two-entry result queue (output register plus skid) sits between the sides,
// so in_stall rises only when both entries hold results
// synchronous active-low reset clears parse state and sets pair_limit to 32
// cfg_ready is always high; write only while the block is idle
module name_value_pair_parser #(
  parameter int NAME_CHARS = nvp_pkg::NVP_NAME_CHARS,
  parameter int MAX_PAIRS  = nvp_pkg::NVP_MAX_PAIRS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nvp_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nvp_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nvp_pkg::NVP_CNT_W-1:0] cfg_data
);

  logic            accept;
  logic            res_valid;
  nvp_pkg::out_t   res_data;
  logic            q_push;
  logic            q_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  assign q_push = accept && res_valid;

  nvp_parser #(
    .NAME_CHARS (NAME_CHARS),
    .MAX_PAIRS  (MAX_PAIRS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_limit (cfg_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  nvp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (res_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_name_value_pair_parser.sv =====
`timescale 1ns / 1ps

module tb_name_value_pair_parser;
  import nvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 4;

  typedef enum logic [1:0] {
    TERM_NUL      = 2'd0,  // separate zero byte ends the text
    TERM_LAST     = 2'd1,  // final_byte set on the last character
    TERM_NUL_LAST = 2'd2   // zero byte that also carries final_byte
  } term_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [NVP_CNT_W-1:0] cfg_data = '0;

  // pair predictor state
  logic [NVP_CNT_W-1:0] limit_reg;
  phase_t               parse_ph;
  conv_t                conv_ph;
  logic [7:0]           name_buf [NVP_STORE_BYTES];
  logic [NVP_LEN_W-1:0] name_len;
  logic                 name_trunc;
  logic [31:0]          magnitude;
  logic                 negative;
  logic [NVP_CNT_W-1:0] pair_cnt;

  out_t        pending_pairs [$];
  logic [7:0]  text_buf [$];
  out_t        want;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  logic        no_gaps = 1'b0;

  name_value_pair_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void reset_pair_state();
    int i;
    for (i = 0; i < NVP_STORE_BYTES; i++) name_buf[i] = '0;
    name_len   = '0;
    name_trunc = 1'b0;
    magnitude  = '0;
    negative   = 1'b0;
    conv_ph    = CV_LEAD;
  endfunction

  function automatic void reset_text_state();
    reset_pair_state();
    parse_ph = PH_NAME;
    pair_cnt = '0;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == NVP_CH_SPACE || (b >= NVP_CH_TAB && b <= NVP_CH_CR);
  endfunction

  // atoi-style conversion, magnitude capped at 2^31
  function automatic void take_value_char(logic [7:0] b);
    logic        digit;
    logic [63:0] m;
    digit = b >= NVP_CH_ZERO && b <= NVP_CH_NINE;
    if (conv_ph == CV_STOP) return;
    if (conv_ph == CV_LEAD) begin
      if (is_blank(b)) return;
      if (b == NVP_CH_PLUS || b == NVP_CH_MINUS) begin
        negative = (b == NVP_CH_MINUS);
        conv_ph  = CV_DIGITS;
        return;
      end
      conv_ph = digit ? CV_DIGITS : CV_STOP;
      if (!digit) return;
    end
    if (!digit) begin
      conv_ph = CV_STOP;
      return;
    end
    m = {32'd0, magnitude} * 64'd10 + 64'(b - NVP_CH_ZERO);
    magnitude = (m > 64'(NVP_MAG_CAP)) ? NVP_MAG_CAP : m[31:0];
  endfunction

  function automatic out_t pack_pair();
    out_t r;
    int   i;
    r = '0;
    for (i = 0; i < NVP_STORE_BYTES; i++) begin
      if (i < 8) r.name_low[8*i +: 8] = name_buf[i];
      else r.name_high[8*(i-8) +: 8] = name_buf[i];
    end
    r.name_length  = name_len;
    r.name_cut     = name_trunc;
    r.pair_value   = negative ? (32'd0 - magnitude)
                              : ((magnitude > NVP_POS_MAX) ? NVP_POS_MAX : magnitude);
    r.pair_present = 1'b1;
    return r;
  endfunction

  // returns 1 when the byte produces a result beat
  function automatic bit parse_byte(input logic [7:0] b, input logic fin, output out_t r);
    logic done;
    logic got_pair;
    int   cap;
    r        = '0;
    done     = (b == NVP_CH_NUL) || fin;
    got_pair = 1'b0;
    cap      = (limit_reg > NVP_MAX_PAIRS) ? NVP_MAX_PAIRS : int'(limit_reg);
    if (parse_ph == PH_NAME && pair_cnt >= cap) parse_ph = PH_DONE;
    if (b != NVP_CH_NUL) begin
      if (parse_ph == PH_NAME) begin
        if (b == NVP_CH_EQ) begin
          parse_ph  = PH_VALUE;
          magnitude = '0;
          negative  = 1'b0;
          conv_ph   = CV_LEAD;
        end else if (name_len < NVP_NAME_CHARS) begin
          name_buf[name_len] = b;
          name_len++;
        end else begin
          name_trunc = 1'b1;
        end
      end else if (parse_ph == PH_VALUE) begin
        if (b == NVP_CH_COMMA) begin
          r        = pack_pair();
          got_pair = 1'b1;
          pair_cnt++;
          reset_pair_state();
          parse_ph = (pair_cnt >= cap) ? PH_DONE : PH_NAME;
        end else begin
          take_value_char(b);
        end
      end
    end
    // value still open at the end of the text
    if (done && !got_pair && parse_ph == PH_VALUE) begin
      r        = pack_pair();
      got_pair = 1'b1;
      pair_cnt++;
    end
    if (!got_pair && !done) return 1'b0;
    r.text_end    = done;
    r.pairs_found = pair_cnt;
    if (done) reset_text_state();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_t  beat;
    out_t r;
    beat.text_byte  = b;
    beat.final_byte = fin;
    while (!no_gaps && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (parse_byte(b, fin, r)) pending_pairs.push_back(r);
  endtask

  task automatic send_text(input term_t kind);
    int i;
    if (text_buf.size() == 0 && kind == TERM_LAST) kind = TERM_NUL_LAST;
    for (i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], kind == TERM_LAST && i == text_buf.size() - 1);
    if (kind != TERM_LAST) send_byte(NVP_CH_NUL, kind == TERM_NUL_LAST);
  endtask

  function automatic void add_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_str(input string s, input term_t kind);
    text_buf.delete();
    add_str(s);
    send_text(kind);
  endtask

  // drop valid, let every pending result drain, then idle for a tail period
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [NVP_CNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  function automatic void make_random_text();
    int unsigned n_pairs, p, len, k;
    string       edge_vals [4];
    logic [7:0]  c;
    edge_vals = '{"2147483647", "2147483648", "2147483649", "4294967296"};
    text_buf.delete();
    if ($urandom_range(9) == 0) begin
      // noise
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) text_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    n_pairs = $urandom_range(0, 5);
    for (p = 0; p < n_pairs; p++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(7) != 0) begin
          c = 8'($urandom_range(8'h61, 8'h7A));
        end else begin
          c = 8'($urandom_range(1, 255));
          if (c == NVP_CH_EQ) c = 8'h51;
        end
        text_buf.push_back(c);
      end
      if ($urandom_range(19) != 0) text_buf.push_back(NVP_CH_EQ);
      len = $urandom_range(0, 2);
      for (k = 0; k < len; k++)
        text_buf.push_back(($urandom_range(3) == 0) ? NVP_CH_SPACE
                                                    : 8'($urandom_range(NVP_CH_TAB, NVP_CH_CR)));
      case ($urandom_range(5))
        0, 1: text_buf.push_back(NVP_CH_MINUS);
        2:    text_buf.push_back(NVP_CH_PLUS);
        3: begin
          if ($urandom_range(3) == 0) begin
            text_buf.push_back(NVP_CH_PLUS);
            text_buf.push_back(NVP_CH_MINUS);
          end
        end
        default: ;
      endcase
      if ($urandom_range(7) == 0) begin
        add_str(edge_vals[$urandom_range(3)]);
      end else begin
        len = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
        for (k = 0; k < len; k++) text_buf.push_back(8'(NVP_CH_ZERO + $urandom_range(9)));
      end
      if ($urandom_range(5) == 0) begin
        // junk after the number, which may stop the conversion
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      if (p != n_pairs - 1 || $urandom_range(1) == 0) text_buf.push_back(NVP_CH_COMMA);
    end
    if ($urandom_range(4) == 0) begin
      len = $urandom_range(1, 3);
      for (k = 0; k < len; k++) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
  endfunction

  task automatic test_directed();
    send_str("= -9999999999", TERM_LAST);  // empty name, negative saturation, no comma
    send_str("k=+7,ab", TERM_NUL);         // end while collecting a name
    send_str("v=", TERM_LAST);             // '=' as the final byte
    send_str("\377=0,", TERM_LAST);        // comma on the final byte
  endtask

  task automatic test_pair_limit();
    write_limit('0);
    send_str("a=1,b=2", TERM_NUL);
    write_limit(6'd1);
    send_str("a=1,b=2,", TERM_LAST);
    write_limit(6'd2);
    send_str("x,y=12z9, w=3,q=4", TERM_NUL_LAST);
  endtask

  task automatic test_backpressure();
    int i;
    // limit above the pair maximum behaves as the maximum
    write_limit('1);
    text_buf.delete();
    for (i = 0; i < NVP_MAX_PAIRS + 2; i++) add_str("n=5,");
    add_str("tail=1");
    hold_requests <= hold_requests + 1;
    send_text(TERM_NUL);
  endtask

  task automatic test_random_texts();
    logic [NVP_CNT_W-1:0] limits [8];
    int unsigned          i, budget;
    limits = '{NVP_LIMIT_RESET, 6'd3, 6'd0, 6'd33, 6'd1,
               6'($urandom_range(63)), 6'd63, 6'd5};
    for (i = 0; i < 8; i++) begin
      write_limit(limits[i]);
      no_gaps <= (i == 0);
      budget = items_sent + 45;
      while (items_sent < budget) begin
        make_random_text();
        send_text(term_t'($urandom_range(2)));
      end
    end
    no_gaps <= 1'b0;
  endtask

  // result sink: random stalls plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_requests != holds_served && hold_left == 0) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 15);
    end
  end

  function automatic void check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("result beat with no pair pending");
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("name_low", want.name_low, out_data.name_low);
        check_field("name_high", want.name_high, out_data.name_high);
        check_field("name_length", want.name_length, out_data.name_length);
        check_field("name_cut", want.name_cut, out_data.name_cut);
        check_field("pair_value", want.pair_value, out_data.pair_value);
        check_field("pair_present", want.pair_present, out_data.pair_present);
        check_field("text_end", want.text_end, out_data.text_end);
        check_field("pairs_found", want.pairs_found, out_data.pairs_found);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_name_value_pair_parser NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    limit_reg = NVP_LIMIT_RESET;
    reset_text_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pair_limit();
    test_backpressure();
    test_random_texts();
    settle();
    if (mismatches == 0) begin
      $display("tb_name_value_pair_parser OK");
    end else begin
      $display("tb_name_value_pair_parser NOT OK");
    end
    $finish;
  end

endmodule
